@@ design/estg_pkg.sv @@
package estg_pkg;

    // Sizes
    localparam int INDEX_BITS      = 20;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
    localparam int QTR_SIZE        = 1 << QTR_BITS;

    // Configuration port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 31;

    typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;
    typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

    localparam cfg_addr_t CFG_PHASE_STEP   = 3'd0;
    localparam cfg_addr_t CFG_SAMPLE_COUNT = 3'd1;
    localparam cfg_addr_t CFG_VOLUME_GAIN  = 3'd2;
    localparam cfg_addr_t CFG_ATTACK_STEP  = 3'd3;
    localparam cfg_addr_t CFG_RELEASE_STEP = 3'd4;

    // Register reset values
    localparam logic [15:0] VOLUME_GAIN_RST  = 16'd16384;
    localparam logic [15:0] ATTACK_STEP_RST  = 16'd74;
    localparam logic [15:0] RELEASE_STEP_RST = 16'd36;

    // Arithmetic constants
    localparam logic [16:0] ENV_ONE    = 17'd65536;
    localparam logic [16:0] OUT_SCALE  = 17'd32000;
    localparam logic [45:0] FULL_SCALE = 46'd1 << 45;
    localparam longint HALF_PI_Q30     = 64'sd1686629713;

    typedef logic [14:0] qmag_t;
    typedef qmag_t qtab_t [QTR_SIZE];

    // round(32767*sin(pi/2 * p / QTR_SIZE)) from a Taylor series to x^9 in Q30
    function automatic qmag_t quarter_sine(int unsigned p);
        longint x;
        longint x2;
        longint term;
        longint sum;
        x    = (longint'(p) * HALF_PI_Q30) >>> QTR_BITS;
        x2   = (x * x) >>> 30;
        term = ((x * x2) >>> 30) / 64'sd6;
        sum  = x - term;
        term = ((term * x2) >>> 30) / 64'sd20;
        sum  = sum + term;
        term = ((term * x2) >>> 30) / 64'sd42;
        sum  = sum - term;
        term = ((term * x2) >>> 30) / 64'sd72;
        sum  = sum + term;
        if (sum < 0)
        begin
            sum = 0;
        end
        sum = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
        if (sum > 64'sd32767)
        begin
            sum = 64'sd32767;
        end
        return qmag_t'(sum);
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        int    k;
        for (k = 0; k < QTR_SIZE; k++)
        begin
            t[k] = quarter_sine(k);
        end
        return t;
    endfunction

    localparam qtab_t QTAB  = build_qtab();
    localparam qmag_t QPEAK = quarter_sine(QTR_SIZE);

endpackage

@@ design/enveloped_sine_tone_generator.sv @@
// Enveloped sine tone generator. Each input beat is one sample tick and yields exactly one
// output beat: a 16-bit signed PCM sample, an active flag and a last flag. The sine comes
// from a 32-bit phase accumulator and a quarter-wave table, is shaped by a linear
// attack/release envelope min(1, attack_step*i, release_step*(count-i)), scaled by
// volume_gain (Q2.14), clamped to full scale and mapped to +-32000. A beat with restart=1
// begins the tone at sample zero; after sample_count samples the output is silent with
// active=0. A tone sample runs through six multiplier passes and then the done state,
// which loads the output register once it is free; a silent beat goes from idle straight
// to done. The input is accepted only while the sequencer is idle, so a new beat is taken
// only once the last has left the sequencer. The single 32x17 multiplier runs six passes
// per sample (attack, release, sine times envelope, gain, two halves of the 32000 scale).
// The output register decouples the sides: a new beat is taken while a result waits.
// Configuration writes are always accepted (cfg_ready is tied high) and must be issued
// only while the block is idle; writes to unused indexes are dropped. There is no
// clearing pass after reset.
module enveloped_sine_tone_generator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  sample,
    output logic                active,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  estg_pkg::cfg_addr_t cfg_index,
    input  estg_pkg::cfg_data_t cfg_data
);
    import estg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ATK  = 3'd1;
    localparam logic [2:0] S_REL  = 3'd2;
    localparam logic [2:0] S_SENV = 3'd3;
    localparam logic [2:0] S_GAIN = 3'd4;
    localparam logic [2:0] S_HI   = 3'd5;
    localparam logic [2:0] S_LO   = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [32:0] IDX_MAX_W = (33'd1 << INDEX_BITS) - 33'd1;

    // Configuration registers
    logic [30:0] phase_step_reg;
    logic [19:0] sample_count_reg;
    logic [15:0] volume_gain_reg;
    logic [15:0] attack_step_reg;
    logic [15:0] release_step_reg;

    // Tone state
    logic [2:0]            state_reg,   state_next;
    logic [INDEX_BITS-1:0] index_reg,   index_next;
    logic [31:0]           phase_reg,   phase_next;
    logic                  running_reg, running_next;
    logic                  silent_reg,  silent_next;

    // Datapath
    logic [14:0] smag_reg, smag_next;
    logic        sneg_reg, sneg_next;
    logic [16:0] env_reg,  env_next;
    logic [45:0] acc_reg,  acc_next;
    logic [44:0] hi_reg,   hi_next;
    logic [14:0] mag_reg,  mag_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] sample_reg,    sample_next;
    logic               active_reg,    active_next;
    logic               last_reg,      last_next;

    // Shared multiplier
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] mul_p;

    logic [32:0]           count_w;
    logic [INDEX_BITS-1:0] count_c;
    logic [INDEX_BITS-1:0] idx_eff;
    logic [31:0]           phase_eff;
    logic                  run_eff;
    logic [1:0]            quad;
    logic [QTR_BITS-1:0]   qr;
    logic [QTR_BITS-1:0]   tab_idx;
    logic [14:0]           tab_mag;
    logic [INDEX_BITS:0]   idx_inc;
    logic                  is_last;
    logic [45:0]           out_sum;
    logic                  in_fire;
    logic                  out_free;
    logic                  out_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == S_DONE) && out_free;

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign active    = active_reg;
    assign last      = last_reg;

    // Saturate the tone length to what the sample index can hold
    assign count_w = 33'(sample_count_reg);
    assign count_c = (count_w > IDX_MAX_W) ? INDEX_BITS'(IDX_MAX_W) : INDEX_BITS'(count_w);

    // Apply restart ahead of the silence check and the table read
    assign run_eff   = restart || running_reg;
    assign idx_eff   = restart ? '0 : index_reg;
    assign phase_eff = restart ? 32'd0 : phase_reg;

    // Quarter-wave lookup: mirror odd quadrants, negate the lower half cycle
    assign quad    = phase_eff[31:30];
    assign qr      = phase_eff[29:32-SINE_TABLE_BITS];
    assign tab_idx = quad[0] ? QTR_BITS'(-qr) : qr;
    assign tab_mag = (quad[0] && (qr == '0)) ? QPEAK : QTAB[tab_idx];

    assign idx_inc = (INDEX_BITS+1)'(index_reg) + (INDEX_BITS+1)'(1);
    assign is_last = (idx_inc == (INDEX_BITS+1)'(count_c));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ATK:
            begin
                mul_a = 32'(index_reg);
                mul_b = 17'(attack_step_reg);
            end
            S_REL:
            begin
                mul_a = 32'(count_c - index_reg);
                mul_b = 17'(release_step_reg);
            end
            S_SENV:
            begin
                mul_a = 32'(smag_reg);
                mul_b = env_reg;
            end
            S_GAIN:
            begin
                mul_a = acc_reg[31:0];
                mul_b = 17'(volume_gain_reg);
            end
            S_HI:
            begin
                mul_a = 32'(acc_reg[45:16]);
                mul_b = OUT_SCALE;
            end
            S_LO:
            begin
                mul_a = 32'(acc_reg[15:0]);
                mul_b = OUT_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = 49'(mul_a) * 49'(mul_b);
    // floor((hi*2^16 + lo) / 2^45), with the low partial product folded in first
    assign out_sum = 46'(hi_reg) + 46'(mul_p[30:16]);

    always_comb
    begin
        state_next     = state_reg;
        index_next     = index_reg;
        phase_next     = phase_reg;
        running_next   = running_reg;
        silent_next    = silent_reg;
        smag_next      = smag_reg;
        sneg_next      = sneg_reg;
        env_next       = env_reg;
        acc_next       = acc_reg;
        hi_next        = hi_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        active_next    = active_reg;
        last_next      = last_reg;

        // Drop the beat held in the output register once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    index_next   = idx_eff;
                    phase_next   = phase_eff;
                    running_next = run_eff;
                    smag_next    = tab_mag;
                    sneg_next    = quad[1];
                    if (!run_eff || (idx_eff >= count_c))
                    begin
                        silent_next = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        silent_next = 1'b0;
                        state_next  = S_ATK;
                    end
                end
            end
            S_ATK:
            begin
                env_next   = (mul_p < 49'(ENV_ONE)) ? mul_p[16:0] : ENV_ONE;
                state_next = S_REL;
            end
            S_REL:
            begin
                if (mul_p < 49'(env_reg))
                begin
                    env_next = mul_p[16:0];
                end
                state_next = S_SENV;
            end
            S_SENV:
            begin
                acc_next   = mul_p[45:0];
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                acc_next   = (mul_p > 49'(FULL_SCALE)) ? FULL_SCALE : mul_p[45:0];
                state_next = S_HI;
            end
            S_HI:
            begin
                hi_next    = mul_p[44:0];
                state_next = S_LO;
            end
            S_LO:
            begin
                mag_next   = out_sum[43:29];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (silent_reg)
                    begin
                        sample_next  = '0;
                        active_next  = 1'b0;
                        last_next    = 1'b0;
                        running_next = 1'b0;
                    end
                    else
                    begin
                        sample_next  = sneg_reg ? -$signed(16'(mag_reg)) : $signed(16'(mag_reg));
                        active_next  = 1'b1;
                        last_next    = is_last;
                        index_next   = INDEX_BITS'(idx_inc);
                        phase_next   = phase_reg + 32'(phase_step_reg);
                        running_next = !is_last;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= '0;
            sample_count_reg <= '0;
            volume_gain_reg  <= VOLUME_GAIN_RST;
            attack_step_reg  <= ATTACK_STEP_RST;
            release_step_reg <= RELEASE_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data[19:0];
                CFG_VOLUME_GAIN:  volume_gain_reg  <= cfg_data[15:0];
                CFG_ATTACK_STEP:  attack_step_reg  <= cfg_data[15:0];
                CFG_RELEASE_STEP: release_step_reg <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            index_reg     <= '0;
            phase_reg     <= '0;
            running_reg   <= 1'b0;
            silent_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            index_reg     <= index_next;
            phase_reg     <= phase_next;
            running_reg   <= running_next;
            silent_reg    <= silent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smag_reg   <= smag_next;
        sneg_reg   <= sneg_next;
        env_reg    <= env_next;
        acc_reg    <= acc_next;
        hi_reg     <= hi_next;
        mag_reg    <= mag_next;
        sample_reg <= sample_next;
        active_reg <= active_next;
        last_reg   <= last_next;
    end

    // A silent beat carries no sample and no last flag
    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !active_reg) |-> (sample_reg == 16'sd0 && !last_reg))
        else $error("silent beat carries data");

    // An accepted beat either starts the envelope pass or goes straight out silent
    a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_ATK || state_reg == S_DONE))
        else $error("bad sequencer path after accept");

    // The tone stops after its final sample
    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |=> !running_reg)
        else $error("tone still running after last sample");

    // The envelope never exceeds unity before it scales the sine
    a_env_unity: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SENV) |-> (env_reg <= ENV_ONE))
        else $error("envelope above unity");

    // A sample never leaves the +-32000 range
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sample_reg <= 16'sd32000 && sample_reg >= -16'sd32000))
        else $error("sample out of range");

endmodule
